@@ hw/rtl/look_at_view_matrix_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the look-at view matrix unit
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_ASSERT_SVH

// Same-cycle implication
`define LAVM_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication
`define LAVM_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ hw/rtl/lavm_pkg.sv @@
// ---------------------------------------------------------------------------
// lavm_pkg
// Shared constants and types of the look-at view matrix unit.
// ---------------------------------------------------------------------------
package lavm_pkg;

	localparam int NRM_STEPS  = 6;
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 31;
	// magnitude, normalise, square, sum, root, numerator, divide, sign
	localparam int UNIT_LAT   = 1 + NRM_STEPS + 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;

	typedef logic [1:0] row_t;
	localparam row_t ROW_SIDE = 2'd0;
	localparam row_t ROW_UP   = 2'd1;
	localparam row_t ROW_FWD  = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ROW1,
		PH_ROW2
	} phase_t;

endpackage

@@ hw/rtl/look_at_view_matrix_unit.sv @@
// ---------------------------------------------------------------------------
// look_at_view_matrix_unit
// Builds the side, true-up and negated-forward rows of a look-at view matrix.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start, accepted if !busy  eye_*, target_*, up_* (Q16.16)
// row       out        valid, one cycle, no stall row_number, col_*, offset,
//                                                degenerate, last
//
// Commands are pipelined: a new one is taken before earlier rows are out, once
// busy has fallen. The row port emits one row a cycle, so busy stays high
// after each accepted transaction to keep successive commands' rows apart.
// Row 0 is followed back to back by rows 1 and 2. The three unit-vector
// pipelines (square root and divide, one bit a stage) set the latency.
// Reset clears the valid chain, the row sequencer and busy.
// ---------------------------------------------------------------------------
`include "look_at_view_matrix_unit_assert.svh"

module look_at_view_matrix_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               valid,
	output logic [1:0]         row_number,
	output logic signed [31:0] col_x,
	output logic signed [31:0] col_y,
	output logic signed [31:0] col_z,
	output logic signed [32:0] offset,
	output logic               degenerate,
	output logic               last
);

	localparam int UL = lavm_pkg::UNIT_LAT;
	localparam int FD = UL + 6;
	localparam int ED = 2 * UL + 6;
	localparam int VT = 2 * UL + 10;

	localparam logic signed [63:0] CROSS_FLOOR = 64'sd68719476736;
	localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
	localparam logic signed [63:0] OFS_MAX     = 64'sd4294967295;
	localparam logic signed [63:0] OFS_MIN     = -64'sd4294967296;

	function automatic logic signed [63:0] round30(input logic signed [63:0] v);
		logic [63:0] m, a;
		m = v[63] ? (64'd0 - v) : v;
		a = (m + 64'd536870912) >> 30;
		return v[63] ? $signed(64'd0 - a) : $signed(a);
	endfunction

	logic accept;
	logic [1:0] gap_q;
	logic vld_q [VT];

	logic [2:0][31:0] eye_s1;
	logic [2:0][63:0] dir_s1, up_s1;

	logic [2:0][31:0] f_u, u0_u, s_u;
	logic ok_f, ok_u0, ok_s;

	logic signed [63:0] xp_s2 [6];
	logic okab_s2;
	logic [2:0][63:0] c_s3;
	logic okab_s3;
	logic [2:0][63:0] c_s4;
	logic okc_s4;

	logic [2:0][31:0] f_dl_q [FD];
	logic [2:0][31:0] eye_dl_q [ED];
	logic ok_dl_q [UL];
	logic [2:0][31:0] s_dl_q [3];

	logic signed [63:0] yp_s5 [6];
	logic ok_s5;
	logic [2:0][63:0] d_s6;
	logic ok_s6;
	logic [2:0][31:0] uu_s7, uu_nx;
	logic ok_s7;

	logic signed [63:0] dp_s8 [9];
	logic [2:0][2:0][31:0] col_s8, col_s9, col_s10;
	logic ok_s8, ok_s9, ok_s10;
	logic [2:0][63:0] dot_s9;
	logic [2:0][32:0] ofs_s10, ofs_nx;

	logic [2:0][31:0] hcol1_q, hcol2_q;
	logic [32:0] hofs1_q, hofs2_q;
	logic hdeg_q;
	lavm_pkg::phase_t ph_q, ph_nx;

	assign accept = start && !busy;
	assign busy   = (gap_q != 2'd0);

	// hold off new commands after each accepted one so that row bursts cannot overlap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
			for (int k = 0; k < VT; k++) vld_q[k] <= 1'b0;
			ph_q <= lavm_pkg::PH_IDLE;
		end else begin
			if (accept) gap_q <= 2'd2;
			else if (gap_q != 2'd0) gap_q <= gap_q - 2'd1;
			vld_q[0] <= accept;
			for (int k = 1; k < VT; k++) vld_q[k] <= vld_q[k - 1];
			ph_q <= ph_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eye_s1 <= {eye_z, eye_y, eye_x};
			dir_s1[0] <= 64'($signed({target_x[31], target_x}) - $signed({eye_x[31], eye_x}));
			dir_s1[1] <= 64'($signed({target_y[31], target_y}) - $signed({eye_y[31], eye_y}));
			dir_s1[2] <= 64'($signed({target_z[31], target_z}) - $signed({eye_z[31], eye_z}));
			up_s1[0] <= 64'(up_x);
			up_s1[1] <= 64'(up_y);
			up_s1[2] <= 64'(up_z);
		end
	end

	lavm_unit u_fwd (.clk(clk), .v(dir_s1), .u(f_u),  .ok(ok_f));
	lavm_unit u_upn (.clk(clk), .v(up_s1),  .u(u0_u), .ok(ok_u0));
	lavm_unit u_sid (.clk(clk), .v(c_s4),   .u(s_u),  .ok(ok_s));

	// round and clamp the true-up components and the row offsets
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [63:0] r;
			logic [63:0] m;
			r = round30($signed(d_s6[i]));
			if (r > ONE_Q30) m = ONE_Q30;
			else if (r < -ONE_Q30) m = -ONE_Q30;
			else m = r;
			uu_nx[i] = m[31:0];
		end
		for (int k = 0; k < 3; k++) begin
			logic signed [63:0] r;
			logic [63:0] m;
			r = round30($signed(dot_s9[k]));
			if (k != 2) r = -r;
			if (r > OFS_MAX) m = OFS_MAX;
			else if (r < OFS_MIN) m = OFS_MIN;
			else m = r;
			ofs_nx[k] = m[32:0];
		end
	end

	always_ff @(posedge clk) begin
		xp_s2[0] <= $signed(f_u[1]) * $signed(u0_u[2]);
		xp_s2[1] <= $signed(f_u[2]) * $signed(u0_u[1]);
		xp_s2[2] <= $signed(f_u[2]) * $signed(u0_u[0]);
		xp_s2[3] <= $signed(f_u[0]) * $signed(u0_u[2]);
		xp_s2[4] <= $signed(f_u[0]) * $signed(u0_u[1]);
		xp_s2[5] <= $signed(f_u[1]) * $signed(u0_u[0]);
		okab_s2  <= ok_f && ok_u0;

		c_s3[0] <= xp_s2[0] - xp_s2[1];
		c_s3[1] <= xp_s2[2] - xp_s2[3];
		c_s3[2] <= xp_s2[4] - xp_s2[5];
		okab_s3 <= okab_s2;

		// up parallel to forward: every cross component below the floor
		c_s4 <= c_s3;
		okc_s4 <= okab_s3 && (
			$signed(c_s3[0]) >= CROSS_FLOOR || $signed(c_s3[0]) <= -CROSS_FLOOR ||
			$signed(c_s3[1]) >= CROSS_FLOOR || $signed(c_s3[1]) <= -CROSS_FLOOR ||
			$signed(c_s3[2]) >= CROSS_FLOOR || $signed(c_s3[2]) <= -CROSS_FLOOR);

		f_dl_q[0] <= f_u;
		for (int k = 1; k < FD; k++) f_dl_q[k] <= f_dl_q[k - 1];
		eye_dl_q[0] <= eye_s1;
		for (int k = 1; k < ED; k++) eye_dl_q[k] <= eye_dl_q[k - 1];
		ok_dl_q[0] <= okc_s4;
		for (int k = 1; k < UL; k++) ok_dl_q[k] <= ok_dl_q[k - 1];
		s_dl_q[0] <= s_u;
		for (int k = 1; k < 3; k++) s_dl_q[k] <= s_dl_q[k - 1];

		// s x f -> true up
		yp_s5[0] <= $signed(s_u[1]) * $signed(f_dl_q[UL + 2][2]);
		yp_s5[1] <= $signed(s_u[2]) * $signed(f_dl_q[UL + 2][1]);
		yp_s5[2] <= $signed(s_u[2]) * $signed(f_dl_q[UL + 2][0]);
		yp_s5[3] <= $signed(s_u[0]) * $signed(f_dl_q[UL + 2][2]);
		yp_s5[4] <= $signed(s_u[0]) * $signed(f_dl_q[UL + 2][1]);
		yp_s5[5] <= $signed(s_u[1]) * $signed(f_dl_q[UL + 2][0]);
		ok_s5 <= ok_dl_q[UL - 1] && ok_s;

		d_s6[0] <= yp_s5[0] - yp_s5[1];
		d_s6[1] <= yp_s5[2] - yp_s5[3];
		d_s6[2] <= yp_s5[4] - yp_s5[5];
		ok_s6 <= ok_s5;

		uu_s7 <= uu_nx;
		ok_s7 <= ok_s6;

		for (int i = 0; i < 3; i++) begin
			dp_s8[i]     <= $signed(s_dl_q[2][i]) * $signed(eye_dl_q[ED - 1][i]);
			dp_s8[3 + i] <= $signed(uu_s7[i]) * $signed(eye_dl_q[ED - 1][i]);
			dp_s8[6 + i] <= $signed(f_dl_q[FD - 1][i]) * $signed(eye_dl_q[ED - 1][i]);
			col_s8[lavm_pkg::ROW_SIDE][i] <= s_dl_q[2][i];
			col_s8[lavm_pkg::ROW_UP][i]   <= uu_s7[i];
			col_s8[lavm_pkg::ROW_FWD][i]  <= 32'd0 - f_dl_q[FD - 1][i];
		end
		ok_s8 <= ok_s7;

		for (int k = 0; k < 3; k++)
			dot_s9[k] <= dp_s8[3 * k] + dp_s8[3 * k + 1] + dp_s8[3 * k + 2];
		col_s9 <= col_s8;
		ok_s9  <= ok_s8;

		// degenerate basis: zero the payload
		col_s10 <= ok_s9 ? col_s9 : '0;
		ofs_s10 <= ok_s9 ? ofs_nx : '0;
		ok_s10  <= ok_s9;
	end

	always_comb begin
		ph_nx = lavm_pkg::PH_IDLE;
		unique case (ph_q)
			lavm_pkg::PH_IDLE: ph_nx = vld_q[VT - 1] ? lavm_pkg::PH_ROW1 : lavm_pkg::PH_IDLE;
			lavm_pkg::PH_ROW1: ph_nx = lavm_pkg::PH_ROW2;
			lavm_pkg::PH_ROW2: ph_nx = lavm_pkg::PH_IDLE;
			default:           ph_nx = lavm_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid <= 1'b0;
		else valid <= vld_q[VT - 1] || (ph_q != lavm_pkg::PH_IDLE);
	end

	always_ff @(posedge clk) begin
		if (vld_q[VT - 1]) begin
			row_number <= lavm_pkg::ROW_SIDE;
			col_x      <= col_s10[lavm_pkg::ROW_SIDE][0];
			col_y      <= col_s10[lavm_pkg::ROW_SIDE][1];
			col_z      <= col_s10[lavm_pkg::ROW_SIDE][2];
			offset     <= ofs_s10[lavm_pkg::ROW_SIDE];
			degenerate <= !ok_s10;
			last       <= 1'b0;
			hcol1_q    <= col_s10[lavm_pkg::ROW_UP];
			hcol2_q    <= col_s10[lavm_pkg::ROW_FWD];
			hofs1_q    <= ofs_s10[lavm_pkg::ROW_UP];
			hofs2_q    <= ofs_s10[lavm_pkg::ROW_FWD];
			hdeg_q     <= !ok_s10;
		end else if (ph_q == lavm_pkg::PH_ROW1) begin
			row_number <= lavm_pkg::ROW_UP;
			col_x      <= hcol1_q[0];
			col_y      <= hcol1_q[1];
			col_z      <= hcol1_q[2];
			offset     <= hofs1_q;
			degenerate <= hdeg_q;
			last       <= 1'b0;
		end else if (ph_q == lavm_pkg::PH_ROW2) begin
			row_number <= lavm_pkg::ROW_FWD;
			col_x      <= hcol2_q[0];
			col_y      <= hcol2_q[1];
			col_z      <= hcol2_q[2];
			offset     <= hofs2_q;
			degenerate <= hdeg_q;
			last       <= 1'b1;
		end
	end

	`LAVM_ASSERT_IMP(a_last_fwd, valid, last == (row_number == lavm_pkg::ROW_FWD), "last off row 2")
	`LAVM_ASSERT_NXT(a_side_up, valid && row_number == lavm_pkg::ROW_SIDE, valid && row_number == lavm_pkg::ROW_UP, "row 1 missing")
	`LAVM_ASSERT_NXT(a_busy, accept, busy, "busy not raised after transaction")
	`LAVM_ASSERT_IMP(a_deg_zero, valid && degenerate, col_x == 32'sd0 && offset == 33'sd0, "degenerate row not zero")

endmodule

@@ hw/rtl/lavm_unit.sv @@
// ---------------------------------------------------------------------------
// lavm_unit
// Pipelined unit vector: normalise, sum of squares, square root, divide.
// Output is Q2.30 per component; ok is low for the zero vector.
// ---------------------------------------------------------------------------
module lavm_unit (
	input  logic             clk,
	input  logic [2:0][63:0] v,
	output logic [2:0][31:0] u,
	output logic             ok
);

	localparam int NS = lavm_pkg::NRM_STEPS;
	localparam int RS = lavm_pkg::SQRT_STEPS;
	localparam int DS = lavm_pkg::DIV_STEPS;

	logic [2:0][63:0] mag_s1;
	logic [2:0]       neg_s1;

	logic [2:0][63:0] nrm_m_s2 [NS];
	logic [2:0]       nrm_neg_s2 [NS];
	logic             nrm_nz_s2 [NS];
	logic [2:0][63:0] nrm_m_nx [NS];

	logic [2:0][29:0] a_s8;
	logic [2:0][59:0] sq_s8;
	logic [2:0]       neg_s8;
	logic             nz_s8;

	logic [2:0][29:0] a_s9;
	logic [61:0]      sum_s9;
	logic [2:0]       neg_s9;
	logic             nz_s9;

	logic [33:0]      rt_rem_s10 [RS];
	logic [30:0]      rt_root_s10 [RS];
	logic [61:0]      rt_src_s10 [RS];
	logic [2:0][29:0] rt_a_s10 [RS];
	logic [2:0]       rt_neg_s10 [RS];
	logic             rt_nz_s10 [RS];
	logic [33:0]      rt_rem_nx [RS];
	logic [30:0]      rt_root_nx [RS];

	logic [2:0][60:0] num_s41;
	logic [30:0]      len_s41;
	logic [2:0]       neg_s41;
	logic             nz_s41;

	logic [2:0][30:0] dv_rem_s42 [DS];
	logic [2:0][30:0] dv_q_s42 [DS];
	logic [2:0][30:0] dv_src_s42 [DS];
	logic [30:0]      dv_len_s42 [DS];
	logic [2:0]       dv_neg_s42 [DS];
	logic             dv_nz_s42 [DS];
	logic [2:0][30:0] dv_rem_nx [DS];
	logic [2:0][30:0] dv_q_nx [DS];
	logic [2:0][30:0] dv_src_nx [DS];

	logic [2:0][31:0] u_s73;
	logic             nz_s73;

	// normalise: shift left until the OR of the magnitudes has bit 63 set
	always_comb begin
		logic [63:0] orv;
		logic [2:0][63:0] pm;
		int k;
		for (int j = 0; j < NS; j++) begin
			pm = (j == 0) ? mag_s1 : nrm_m_s2[(j == 0) ? 0 : j - 1];
			k = 32 >> j;
			orv = pm[0] | pm[1] | pm[2];
			if ((orv >> (64 - k)) == 64'd0) begin
				for (int i = 0; i < 3; i++) nrm_m_nx[j][i] = pm[i] << k;
			end else begin
				nrm_m_nx[j] = pm;
			end
		end
	end

	// square root, two radicand bits per stage
	always_comb begin
		logic [33:0] prem, t, tr;
		logic [30:0] proot;
		logic [61:0] psrc;
		for (int j = 0; j < RS; j++) begin
			if (j == 0) begin
				prem  = 34'd0;
				proot = 31'd0;
				psrc  = sum_s9;
			end else begin
				prem  = rt_rem_s10[j - 1];
				proot = rt_root_s10[j - 1];
				psrc  = rt_src_s10[j - 1];
			end
			t  = {prem[31:0], psrc[61:60]};
			tr = {1'b0, proot, 2'b01};
			if (t >= tr) begin
				rt_rem_nx[j]  = t - tr;
				rt_root_nx[j] = {proot[29:0], 1'b1};
			end else begin
				rt_rem_nx[j]  = t;
				rt_root_nx[j] = {proot[29:0], 1'b0};
			end
		end
	end

	// restoring division, one quotient bit per stage
	always_comb begin
		logic [30:0] prem, pq, psrc, plen;
		logic [31:0] t;
		for (int j = 0; j < DS; j++) begin
			for (int i = 0; i < 3; i++) begin
				if (j == 0) begin
					prem = {1'b0, num_s41[i][60:31]};
					pq   = 31'd0;
					psrc = num_s41[i][30:0];
					plen = len_s41;
				end else begin
					prem = dv_rem_s42[j - 1][i];
					pq   = dv_q_s42[j - 1][i];
					psrc = dv_src_s42[j - 1][i];
					plen = dv_len_s42[j - 1];
				end
				t = {prem, psrc[30]};
				if (t >= {1'b0, plen}) begin
					dv_rem_nx[j][i] = 31'(t - {1'b0, plen});
					dv_q_nx[j][i]   = {pq[29:0], 1'b1};
				end else begin
					dv_rem_nx[j][i] = t[30:0];
					dv_q_nx[j][i]   = {pq[29:0], 1'b0};
				end
				dv_src_nx[j][i] = {psrc[29:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= v[i][63] ? (64'd0 - v[i]) : v[i];
			neg_s1[i] <= v[i][63];
		end

		for (int j = 0; j < NS; j++) begin
			nrm_m_s2[j] <= nrm_m_nx[j];
			if (j == 0) begin
				nrm_neg_s2[j] <= neg_s1;
				nrm_nz_s2[j]  <= |(mag_s1[0] | mag_s1[1] | mag_s1[2]);
			end else begin
				nrm_neg_s2[j] <= nrm_neg_s2[j - 1];
				nrm_nz_s2[j]  <= nrm_nz_s2[j - 1];
			end
		end

		for (int i = 0; i < 3; i++) begin
			a_s8[i]  <= nrm_m_s2[NS - 1][i][63:34];
			sq_s8[i] <= nrm_m_s2[NS - 1][i][63:34] * nrm_m_s2[NS - 1][i][63:34];
		end
		neg_s8 <= nrm_neg_s2[NS - 1];
		nz_s8  <= nrm_nz_s2[NS - 1];

		a_s9   <= a_s8;
		sum_s9 <= {2'b00, sq_s8[0]} + {2'b00, sq_s8[1]} + {2'b00, sq_s8[2]};
		neg_s9 <= neg_s8;
		nz_s9  <= nz_s8;

		for (int j = 0; j < RS; j++) begin
			rt_rem_s10[j]  <= rt_rem_nx[j];
			rt_root_s10[j] <= rt_root_nx[j];
			if (j == 0) begin
				rt_src_s10[j] <= {sum_s9[59:0], 2'b00};
				rt_a_s10[j]   <= a_s9;
				rt_neg_s10[j] <= neg_s9;
				rt_nz_s10[j]  <= nz_s9;
			end else begin
				rt_src_s10[j] <= {rt_src_s10[j - 1][59:0], 2'b00};
				rt_a_s10[j]   <= rt_a_s10[j - 1];
				rt_neg_s10[j] <= rt_neg_s10[j - 1];
				rt_nz_s10[j]  <= rt_nz_s10[j - 1];
			end
		end

		// round to nearest: add half the length before dividing
		for (int i = 0; i < 3; i++) begin
			num_s41[i] <= {1'b0, rt_a_s10[RS - 1][i], 30'd0} +
				61'(rt_root_s10[RS - 1] >> 1);
		end
		len_s41 <= rt_root_s10[RS - 1];
		neg_s41 <= rt_neg_s10[RS - 1];
		nz_s41  <= rt_nz_s10[RS - 1];

		for (int j = 0; j < DS; j++) begin
			dv_rem_s42[j] <= dv_rem_nx[j];
			dv_q_s42[j]   <= dv_q_nx[j];
			dv_src_s42[j] <= dv_src_nx[j];
			if (j == 0) begin
				dv_len_s42[j] <= len_s41;
				dv_neg_s42[j] <= neg_s41;
				dv_nz_s42[j]  <= nz_s41;
			end else begin
				dv_len_s42[j] <= dv_len_s42[j - 1];
				dv_neg_s42[j] <= dv_neg_s42[j - 1];
				dv_nz_s42[j]  <= dv_nz_s42[j - 1];
			end
		end

		for (int i = 0; i < 3; i++) begin
			u_s73[i] <= dv_neg_s42[DS - 1][i] ? (32'd0 - {1'b0, dv_q_s42[DS - 1][i]})
				: {1'b0, dv_q_s42[DS - 1][i]};
		end
		nz_s73 <= dv_nz_s42[DS - 1];
	end

	assign u  = u_s73;
	assign ok = nz_s73;

endmodule
